@@ hdl/uot_pkg.sv @@
// ----------------------------------------------------------------------------
// uot_pkg
// Shared types and constants of the oversampled UART transceiver.
// ----------------------------------------------------------------------------
package uot_pkg;

  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int RX_COUNT_W = 6;
  localparam int FRAME_BITS = 10;

  // Receiver phase: data bits 0..7, stop bit from 8 up, start-bit search.
  localparam logic [3:0] RX_SEARCH    = 4'hF;
  localparam logic [3:0] RX_STOP_BIT  = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_WRITE = 3'd1,
    OP_READ  = 3'd2,
    OP_PEEK  = 3'd3,
    OP_FLUSH = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INVERSE     = 2'd0,
    CFG_HALF_DUPLEX = 2'd1,
    CFG_RX_ENABLE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e        op;
    logic       rx_pin;
    logic [7:0] tx_data;
  } item_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic                 data;
  } cfg_t;

  typedef struct packed {
    logic                  tx_pin;
    logic                  tx_busy;
    logic                  write_refused;
    logic                  read_valid;
    logic [RX_COUNT_W-1:0] rx_count;
    logic                  overflow;
  } status_t;

endpackage

@@ hdl/uot_ram.sv @@
// ----------------------------------------------------------------------------
// uot_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module uot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/uot_engine.sv @@
// ----------------------------------------------------------------------------
// uot_engine
// Receiver, transmitter, ring pointers and configuration state. Drives the
// ring memory ports and reports the status after each request.
// ----------------------------------------------------------------------------
module uot_engine #(
  parameter int RING_DEPTH    = 64,
  parameter int TICKS_PER_BIT = 3,
  parameter int GUARD_BITS    = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  uot_pkg::item_t                item_i,
  input  uot_pkg::cfg_t                 cfg_i,
  output uot_pkg::status_t              status_o,
  output logic                          ram_we_o,
  output logic [$clog2(RING_DEPTH)-1:0] ram_waddr_o,
  output logic [7:0]                    ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(RING_DEPTH)-1:0] ram_raddr_o
);
  import uot_pkg::*;

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int CW  = AW + 1;
  localparam int RXW = $clog2(TICKS_PER_BIT + 2);
  localparam int TXW = $clog2(TICKS_PER_BIT + 1);
  localparam int SW  = $clog2(FRAME_BITS + TICKS_PER_BIT * GUARD_BITS + 2);
  localparam logic [SW-1:0]  GUARD_END = SW'(FRAME_BITS + TICKS_PER_BIT * GUARD_BITS);
  localparam logic [SW-1:0]  FRAME_END = SW'(FRAME_BITS);
  localparam logic [AW-1:0]  PTR_LAST  = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0]  DEPTH_CW  = CW'(RING_DEPTH);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic            inv_q, inv_d, hdx_q, hdx_d, rxen_q, rxen_d;
  logic [3:0]      rx_phase_q, rx_phase_d;
  logic [RXW-1:0]  rx_wait_q, rx_wait_d, rx_w_dec;
  logic [7:0]      rx_shift_q, rx_shift_d;
  logic [AW-1:0]   head_q, head_d, tail_q, tail_d, tail_inc;
  logic            ovf_q, ovf_d;
  logic [9:0]      tx_shift_q, tx_shift_d;
  logic [SW-1:0]   tx_step_q, tx_step_d, step_inc;
  logic [TXW-1:0]  tx_wait_q, tx_wait_d, tx_w_dec;
  logic            active_q, active_d, line_q, line_d, level_q, level_d;
  logic            rx_bit, refused, rd_valid;
  logic [CW-1:0]   count;

  assign rx_w_dec = (rx_wait_q != '0) ? rx_wait_q - 1'b1 : '0;
  assign tx_w_dec = (tx_wait_q != '0) ? tx_wait_q - 1'b1 : '0;
  assign rx_bit   = item_i.rx_pin ^ inv_q;
  assign tail_inc = ptr_inc(tail_q);
  assign step_inc = tx_step_q + 1'b1;

  always_comb begin
    inv_d = inv_q;       hdx_d = hdx_q;           rxen_d = rxen_q;
    rx_phase_d = rx_phase_q; rx_wait_d = rx_wait_q; rx_shift_d = rx_shift_q;
    head_d = head_q;     tail_d = tail_q;         ovf_d = ovf_q;
    tx_shift_d = tx_shift_q; tx_step_d = tx_step_q; tx_wait_d = tx_wait_q;
    active_d = active_q; line_d = line_q;         level_d = level_q;
    ram_we_o = 1'b0;     ram_waddr_o = tail_q;    ram_wdata_o = rx_shift_q;
    ram_re_o = 1'b0;     ram_raddr_o = head_q;
    refused = 1'b0;      rd_valid = 1'b0;

    if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_INVERSE: begin
          inv_d = cfg_i.data;
          if (!active_q) level_d = ~cfg_i.data;
        end
        CFG_HALF_DUPLEX: hdx_d = cfg_i.data;
        CFG_RX_ENABLE: begin
          if (cfg_i.data && !rxen_q) begin
            rx_wait_d  = RXW'(1);
            rx_phase_d = RX_SEARCH;
            if (!hdx_q) line_d = 1'b1;
          end else if (!cfg_i.data && rxen_q) begin
            if (hdx_q && line_q) level_d = ~inv_q;
            line_d = 1'b0;
          end
          rxen_d = cfg_i.data;
        end
        default: ;
      endcase
    end else if (acc_i) begin
      case (item_i.op)
        OP_TICK: begin
          if (line_q) begin
            if (rx_w_dec != '0) begin
              rx_wait_d = rx_w_dec;
            end else if (rx_phase_q == RX_SEARCH) begin
              if (!rx_bit) begin
                rx_phase_d = 4'd0;
                rx_wait_d  = RXW'(TICKS_PER_BIT + 1);
                rx_shift_d = 8'd0;
              end else begin
                rx_wait_d = RXW'(1);
              end
            end else if (rx_phase_q >= RX_STOP_BIT) begin
              if (rx_bit) begin
                if (tail_inc != head_q) begin
                  ram_we_o = 1'b1;
                  tail_d   = tail_inc;
                end else begin
                  ovf_d = 1'b1;
                end
              end
              rx_wait_d  = RXW'(1);
              rx_phase_d = RX_SEARCH;
            end else begin
              rx_shift_d = {rx_bit, rx_shift_q[7:1]};
              rx_phase_d = rx_phase_q + 4'd1;
              rx_wait_d  = RXW'(TICKS_PER_BIT);
            end
          end
          if (active_q) begin
            if (tx_w_dec != '0) begin
              tx_wait_d = tx_w_dec;
            end else if (tx_step_q < FRAME_END) begin
              tx_step_d  = step_inc;
              level_d    = tx_shift_q[0];
              tx_shift_d = {1'b0, tx_shift_q[9:1]};
              tx_wait_d  = TXW'(TICKS_PER_BIT);
            end else begin
              tx_step_d = step_inc;
              tx_wait_d = TXW'(1);
              // End of the guard: a half-duplex line turns back to receive.
              if (step_inc > GUARD_END) begin
                if (hdx_q && rxen_q && !line_q) begin
                  rx_phase_d = RX_SEARCH;
                  rx_wait_d  = RXW'(2);
                  line_d     = 1'b1;
                end
                active_d = 1'b0;
              end
            end
          end
        end
        OP_WRITE: begin
          if (active_q && tx_step_q <= FRAME_END) begin
            refused = 1'b1;
          end else begin
            tx_shift_d = inv_q ? ~{1'b1, item_i.tx_data, 1'b0} : {1'b1, item_i.tx_data, 1'b0};
            tx_step_d  = '0;
            tx_wait_d  = TXW'(TICKS_PER_BIT);
            if (hdx_q && line_q) begin
              level_d = ~inv_q;
              line_d  = 1'b0;
            end
            active_d = 1'b1;
          end
        end
        OP_READ, OP_PEEK: begin
          if (head_q != tail_q) begin
            rd_valid = 1'b1;
            ram_re_o = 1'b1;
            if (item_i.op == OP_READ) head_d = ptr_inc(head_q);
          end
        end
        OP_FLUSH: begin
          head_d = '0;
          tail_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    count = {1'b0, tail_d} - {1'b0, head_d};
    if (tail_d < head_d) count = count + DEPTH_CW;
  end

  assign status_o.tx_pin        = level_d;
  assign status_o.tx_busy       = active_d;
  assign status_o.write_refused = refused;
  assign status_o.read_valid    = rd_valid;
  assign status_o.rx_count      = RX_COUNT_W'(count);
  assign status_o.overflow      = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;  hdx_q <= 1'b0;  rxen_q <= 1'b0;
      rx_phase_q <= RX_SEARCH;  rx_wait_q <= RXW'(1);  rx_shift_q <= 8'd0;
      head_q <= '0;  tail_q <= '0;  ovf_q <= 1'b0;
      tx_shift_q <= '0;  tx_step_q <= '0;  tx_wait_q <= TXW'(1);
      active_q <= 1'b0;  line_q <= 1'b0;  level_q <= 1'b1;
    end else begin
      inv_q <= inv_d;  hdx_q <= hdx_d;  rxen_q <= rxen_d;
      rx_phase_q <= rx_phase_d;  rx_wait_q <= rx_wait_d;  rx_shift_q <= rx_shift_d;
      head_q <= head_d;  tail_q <= tail_d;  ovf_q <= ovf_d;
      tx_shift_q <= tx_shift_d;  tx_step_q <= tx_step_d;  tx_wait_q <= tx_wait_d;
      active_q <= active_d;  line_q <= line_d;  level_q <= level_d;
    end
  end

endmodule

@@ hdl/oversampled_uart_transceiver_core.sv @@
// ----------------------------------------------------------------------------
// oversampled_uart_transceiver_core
// UART 8N1 transceiver stepped by oversampling ticks, with a receive ring.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Contents
//  s_axis    in         tvalid/tready        request: op, rx_pin, tx_data
//  m_axis    out        tvalid/tready        result: line and ring status
//  cfg       in         cfg_we_i (no wait)   inverse_logic, half_duplex, rx_enable
//
// One request is accepted per clock cycle unless a stalled output backs up stage one.
// Its result leaves after the registered read of the ring memory and the output register.
// Reset clears all control state; the ring memory needs no clearing pass,
// since the head and tail pointers keep unwritten entries out of reach.
// A stalled output holds one result and still lets one more request in.
// ----------------------------------------------------------------------------
module oversampled_uart_transceiver_core #(
  parameter int RING_DEPTH    = 64,
  parameter int TICKS_PER_BIT = 3,
  parameter int GUARD_BITS    = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // rx_pin, tx_data, zero pad
  input  logic [uot_pkg::OP_W-1:0]        s_axis_tuser,  // op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tx_pin, tx_busy, write_refused, read_valid, read_data, rx_count, overflow, pad
  output logic [23:0]                     m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [uot_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic                            cfg_data_i
);
  import uot_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);

  item_t   item;
  cfg_t    cfg;
  status_t status;
  logic    acc;
  logic    ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Stage one waits for the ring read data; the output stage holds the result.
  logic    s1_v_q, s1_v_d, s1_adv;
  status_t s1_st_q;
  logic    out_v_q, out_v_d;
  status_t out_st_q;
  logic [7:0] out_data_q;

  assign item.op      = op_e'(s_axis_tuser);
  assign item.rx_pin  = s_axis_tdata[0];
  assign item.tx_data = s_axis_tdata[8:1];

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign s1_adv        = s1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || s1_adv;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign s1_v_d        = acc || (s1_v_q && !s1_adv);
  assign out_v_d       = s1_adv || (out_v_q && !m_axis_tready);

  uot_engine #(
    .RING_DEPTH   (RING_DEPTH),
    .TICKS_PER_BIT(TICKS_PER_BIT),
    .GUARD_BITS   (GUARD_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .item_i     (item),
    .cfg_i      (cfg),
    .status_o   (status),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr)
  );

  // The read data register only changes on an accepted read, which can only happen
  // when stage one is empty or moves on, so a waiting result keeps its byte.
  uot_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_st_q <= status;
    end
    if (s1_adv) begin
      out_st_q   <= s1_st_q;
      out_data_q <= s1_st_q.read_valid ? ram_rdata : 8'd0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, out_st_q.overflow, out_st_q.rx_count, out_data_q,
                          out_st_q.read_valid, out_st_q.write_refused,
                          out_st_q.tx_busy, out_st_q.tx_pin};

  // The ring is never written and read in the same cycle.
  a_ram_ports : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("ring written and read in one cycle");

  // A ring read always belongs to a request that sits in stage one next cycle.
  a_read_tracked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> s1_v_q)
    else $error("ring read data without a waiting request");

  // A result without a found byte carries zero read data.
  a_read_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[3]) |-> (m_axis_tdata[11:4] == 8'd0))
    else $error("read data without a valid read");

endmodule
